### rtl/core/srqp_pkg.sv
package srqp_pkg;

  localparam logic [4:0] CODE_PROTOCOL     = 5'd0;
  localparam logic [4:0] CODE_HOSTNAME     = 5'd1;
  localparam logic [4:0] CODE_GAME_DESC    = 5'd4;
  localparam logic [4:0] CODE_APP_ID       = 5'd5;
  localparam logic [4:0] CODE_SECURE       = 5'd12;
  localparam logic [4:0] CODE_SHIP_MODE    = 5'd13;
  localparam logic [4:0] CODE_VERSION      = 5'd16;
  localparam logic [4:0] CODE_EDF          = 5'd17;
  localparam logic [4:0] CODE_PORT         = 5'd18;
  localparam logic [4:0] CODE_STEAM_ID     = 5'd19;
  localparam logic [4:0] CODE_RELAY_PORT   = 5'd20;
  localparam logic [4:0] CODE_RELAY_NAME   = 5'd21;
  localparam logic [4:0] CODE_KEYWORDS     = 5'd22;
  localparam logic [4:0] CODE_GAME_ID      = 5'd23;
  localparam logic [4:0] CODE_CHALLENGE    = 5'd24;
  localparam logic [4:0] CODE_PLAYER_COUNT = 5'd25;
  localparam logic [4:0] CODE_PLAYER_INDEX = 5'd26;
  localparam logic [4:0] CODE_PLAYER_NAME  = 5'd27;
  localparam logic [4:0] CODE_PLAYER_SCORE = 5'd28;
  localparam logic [4:0] CODE_PLAYER_TIME  = 5'd29;
  localparam logic [4:0] CODE_NONE         = 5'd30;

  // parse phases share the field code space
  localparam logic [4:0] PH_HEADER = 5'd30;
  localparam logic [4:0] PH_DONE   = 5'd31;

  localparam logic [7:0] TYPE_INFO      = 8'h49;
  localparam logic [7:0] TYPE_CHALLENGE = 8'h41;
  localparam logic [7:0] TYPE_PLAYERS   = 8'h44;

  localparam logic [7:0] EDF_PORT     = 8'h80;
  localparam logic [7:0] EDF_STEAM_ID = 8'h10;
  localparam logic [7:0] EDF_RELAY    = 8'h40;
  localparam logic [7:0] EDF_KEYWORDS = 8'h20;
  localparam logic [7:0] EDF_GAME_ID  = 8'h01;

  localparam logic [2:0] TYPE_BYTE_POS = 3'd4;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [4:0]  code;
    logic [63:0] value;
    logic [6:0]  slot;
    logic        str_end;
    logic        pkt_end;
  } result_t;

  function automatic logic is_string(input logic [4:0] ph);
    is_string = (ph >= CODE_HOSTNAME && ph <= CODE_GAME_DESC) || ph == CODE_VERSION ||
                ph == CODE_RELAY_NAME || ph == CODE_KEYWORDS || ph == CODE_PLAYER_NAME;
  endfunction

  // byte count of a fixed field
  function automatic logic [3:0] field_bytes(input logic [4:0] ph);
    unique case (ph)
      CODE_APP_ID, CODE_PORT, CODE_RELAY_PORT:                 field_bytes = 4'd2;
      CODE_STEAM_ID, CODE_GAME_ID:                             field_bytes = 4'd8;
      CODE_CHALLENGE, CODE_PLAYER_SCORE, CODE_PLAYER_TIME:     field_bytes = 4'd4;
      default:                                                 field_bytes = 4'd1;
    endcase
  endfunction

endpackage

### rtl/core/srqp_front.sv
module srqp_front import srqp_pkg::*; #(
  parameter int unsigned PLAYER_SLOTS     = 128,
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        push,
  output result_t     push_item
);

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);

  logic [15:0]      special_app_id_r;
  logic [4:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [15:0]      seen_app_r, seen_app_nxt;
  logic [7:0]       left_r, left_nxt;
  logic [6:0]       cur_r, cur_nxt;

  function automatic logic [4:0] edf_after(input logic [7:0] f, input logic [2:0] k);
    logic [4:0] sel;
    sel = {|(f & EDF_PORT), |(f & EDF_STEAM_ID), |(f & EDF_RELAY),
           |(f & EDF_KEYWORDS), |(f & EDF_GAME_ID)};
    priority if (k <= 3'd0 && sel[4]) edf_after = CODE_PORT;
    else if (k <= 3'd1 && sel[3]) edf_after = CODE_STEAM_ID;
    else if (k <= 3'd2 && sel[2]) edf_after = CODE_RELAY_PORT;
    else if (k <= 3'd3 && sel[1]) edf_after = CODE_KEYWORDS;
    else if (k <= 3'd4 && sel[0]) edf_after = CODE_GAME_ID;
    else edf_after = PH_DONE;
  endfunction

  logic [63:0] acc_new;
  logic [7:0]  clamped;
  logic [7:0]  left_dec;
  logic [4:0]  ph_next;
  logic        have;
  result_t     res;

  always_comb begin
    acc_new  = acc_r | (64'(data_byte) << {idx_r, 3'b000});
    clamped  = (acc_new[7:0] > 8'(PLAYER_SLOTS)) ? 8'(PLAYER_SLOTS) : acc_new[7:0];
    left_dec = left_r - 8'd1;
    phase_nxt = phase_r; pos_nxt = pos_r; acc_nxt = acc_r; idx_nxt = idx_r;
    flags_nxt = flags_r; seen_app_nxt = seen_app_r; left_nxt = left_r; cur_nxt = cur_r;
    have = 1'b0;
    res  = '{code: CODE_NONE, value: 64'd0, slot: 7'd0, str_end: 1'b0, pkt_end: 1'b0};

    // phase after the current field completes
    unique case (phase_r)
      CODE_SECURE:       ph_next = (seen_app_r == special_app_id_r) ? CODE_SHIP_MODE
                                                                    : CODE_VERSION;
      CODE_EDF:          ph_next = edf_after(acc_new[7:0], 3'd0);
      CODE_PORT:         ph_next = edf_after(flags_r, 3'd1);
      CODE_STEAM_ID:     ph_next = edf_after(flags_r, 3'd2);
      CODE_RELAY_NAME:   ph_next = edf_after(flags_r, 3'd3);
      CODE_KEYWORDS:     ph_next = edf_after(flags_r, 3'd4);
      CODE_GAME_ID, CODE_CHALLENGE: ph_next = PH_DONE;
      CODE_PLAYER_COUNT: ph_next = (clamped != 8'd0) ? CODE_PLAYER_INDEX : PH_DONE;
      CODE_PLAYER_TIME:  ph_next = (left_dec != 8'd0) ? CODE_PLAYER_INDEX : PH_DONE;
      default:           ph_next = phase_r + 5'd1;
    endcase

    if (pos_r < POS_W'(MAX_PACKET_BYTES)) begin
      if (phase_r == PH_HEADER) begin
        if (pos_r == POS_W'(TYPE_BYTE_POS)) begin
          priority if (data_byte == TYPE_INFO) phase_nxt = CODE_PROTOCOL;
          else if (data_byte == TYPE_CHALLENGE) phase_nxt = CODE_CHALLENGE;
          else if (data_byte == TYPE_PLAYERS) phase_nxt = CODE_PLAYER_COUNT;
          else phase_nxt = PH_DONE;
        end
      end else if (phase_r != PH_DONE) begin
        if (phase_r >= CODE_PLAYER_INDEX && phase_r <= CODE_PLAYER_TIME) res.slot = cur_r;
        if (is_string(phase_r)) begin
          have = 1'b1;
          res.code = phase_r;
          res.value = 64'(data_byte);
          res.str_end = (data_byte == 8'd0);
          if (data_byte == 8'd0) phase_nxt = ph_next;
        end else if ((4'(idx_r) + 4'd1) < field_bytes(phase_r)) begin
          acc_nxt = acc_new;
          idx_nxt = idx_r + 3'd1;
        end else begin
          acc_nxt = 64'd0;
          idx_nxt = 3'd0;
          have = 1'b1;
          res.code = phase_r;
          res.value = acc_new;
          phase_nxt = ph_next;
          if (phase_r == CODE_APP_ID) seen_app_nxt = acc_new[15:0];
          else if (phase_r == CODE_EDF) flags_nxt = acc_new[7:0];
          else if (phase_r == CODE_PLAYER_COUNT) begin
            res.value = 64'(clamped);
            left_nxt = clamped;
            cur_nxt = 7'd0;
          end else if (phase_r == CODE_CHALLENGE) have = last_byte;
          else if (phase_r == CODE_PLAYER_SCORE) res.value = {{32{acc_new[31]}}, acc_new[31:0]};
          else if (phase_r == CODE_PLAYER_TIME) begin
            left_nxt = left_dec;
            if (left_dec != 8'd0) cur_nxt = cur_r + 7'd1;
          end
        end
      end
      pos_nxt = pos_r + POS_W'(1);
    end

    if (!have) res = '{code: CODE_NONE, value: 64'd0, slot: 7'd0, str_end: 1'b0, pkt_end: 1'b0};
    if (last_byte) begin
      have = 1'b1;
      res.pkt_end = 1'b1;
      phase_nxt = PH_HEADER; pos_nxt = '0; acc_nxt = 64'd0; idx_nxt = 3'd0;
      flags_nxt = 8'd0; seen_app_nxt = 16'd0; left_nxt = 8'd0; cur_nxt = 7'd0;
    end
  end

  assign push      = accept && have;
  assign push_item = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      special_app_id_r <= 16'd2400;
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      acc_r      <= 64'd0;
      idx_r      <= 3'd0;
      flags_r    <= 8'd0;
      seen_app_r <= 16'd0;
      left_r     <= 8'd0;
      cur_r      <= 7'd0;
    end else begin
      if (cfg_we) special_app_id_r <= cfg_wdata;
      if (accept) begin
        phase_r    <= phase_nxt;
        pos_r      <= pos_nxt;
        acc_r      <= acc_nxt;
        idx_r      <= idx_nxt;
        flags_r    <= flags_nxt;
        seen_app_r <= seen_app_nxt;
        left_r     <= left_nxt;
        cur_r      <= cur_nxt;
      end
    end
  end

endmodule

### rtl/core/srqp_queue.sv
module srqp_queue import srqp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_item,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_item
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  result_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             pop;

  assign full      = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_item  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PTR_W'(1);
      if (pop) rd_r <= rd_r + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/core/server_query_reply_parser.sv
// a result is written into the result queue when the byte that causes it is accepted, and is offered from there
// throughput: one byte per cycle while in_stall is low; the parse state updates once per byte in the front
// a four-entry result queue lets bytes keep flowing while out_stall is held briefly
// reset: synchronous active-low rst_n clears the parse state and the queue and loads
// special_app_id with 2400
module server_query_reply_parser import srqp_pkg::*; #(
  parameter int unsigned PLAYER_SLOTS     = 128,
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_field_code,
  output logic [63:0] out_field_value,
  output logic [6:0]  out_player_slot,
  output logic        out_string_end,
  output logic        out_packet_end
);

  logic    full, push;
  result_t push_item, out_item;

  assign in_stall = full;

  srqp_front #(
    .PLAYER_SLOTS    (PLAYER_SLOTS),
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (in_valid && !full),
    .data_byte(in_data_byte),
    .last_byte(in_last_byte),
    .push     (push),
    .push_item(push_item)
  );

  srqp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  assign out_field_code  = out_item.code;
  assign out_field_value = out_item.value;
  assign out_player_slot = out_item.slot;
  assign out_string_end  = out_item.str_end;
  assign out_packet_end  = out_item.pkt_end;

endmodule

### sim/server_query_reply_parser_tb.sv
`timescale 1ns / 100ps

module server_query_reply_parser_tb;
  import srqp_pkg::*;

  localparam int SLOT_LIMIT = 128;
  localparam int BYTE_LIMIT = 2048;
  localparam logic [7:0] TYPE_UNKNOWN = 8'h58;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_field_code;
  logic [63:0] out_field_value;
  logic [6:0]  out_player_slot;
  logic        out_string_end;
  logic        out_packet_end;

  server_query_reply_parser dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_field_code(out_field_code), .out_field_value(out_field_value),
    .out_player_slot(out_player_slot), .out_string_end(out_string_end),
    .out_packet_end(out_packet_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser shadow state
  logic [15:0] ship_app_id;
  logic [4:0]  phase;
  int          byte_pos;
  logic [63:0] acc;
  int          acc_idx;
  logic [7:0]  edf_flags;
  logic [15:0] app_id;
  int          players_left;
  logic [6:0]  player_no;

  result_t     field_q[$];
  logic [7:0]  pkt[$];
  int          errors = 0;
  int          items_sent = 0;
  int          fields_seen = 0;
  int          datagrams = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;

  logic [7:0] edf_bit[5];
  logic [4:0] edf_code[5];
  initial begin
    edf_bit  = '{EDF_PORT, EDF_STEAM_ID, EDF_RELAY, EDF_KEYWORDS, EDF_GAME_ID};
    edf_code = '{CODE_PORT, CODE_STEAM_ID, CODE_RELAY_PORT, CODE_KEYWORDS, CODE_GAME_ID};
  end

  function automatic void clear_parse();
    phase = PH_HEADER;
    byte_pos = 0;
    acc = '0;
    acc_idx = 0;
    edf_flags = '0;
    app_id = '0;
    players_left = 0;
    player_no = '0;
  endfunction

  function automatic bit text_phase(input logic [4:0] p);
    return (p >= CODE_HOSTNAME && p <= CODE_GAME_DESC) || p == CODE_VERSION ||
           p == CODE_RELAY_NAME || p == CODE_KEYWORDS || p == CODE_PLAYER_NAME;
  endfunction

  function automatic int width_of(input logic [4:0] p);
    case (p)
      CODE_APP_ID, CODE_PORT, CODE_RELAY_PORT: return 2;
      CODE_STEAM_ID, CODE_GAME_ID: return 8;
      CODE_CHALLENGE, CODE_PLAYER_SCORE, CODE_PLAYER_TIME: return 4;
      default: return 1;
    endcase
  endfunction

  function automatic logic [4:0] next_optional(input int k);
    for (int i = k; i < 5; i++)
      if ((edf_flags & edf_bit[i]) != 0) return edf_code[i];
    return PH_DONE;
  endfunction

  function automatic logic [4:0] advance(input logic [4:0] p);
    case (p)
      CODE_SECURE: return (app_id == ship_app_id) ? CODE_SHIP_MODE : CODE_VERSION;
      CODE_EDF: return next_optional(0);
      CODE_PORT: return next_optional(1);
      CODE_STEAM_ID: return next_optional(2);
      CODE_RELAY_NAME: return next_optional(3);
      CODE_KEYWORDS: return next_optional(4);
      CODE_GAME_ID, CODE_CHALLENGE: return PH_DONE;
      CODE_PLAYER_COUNT: return (players_left != 0) ? CODE_PLAYER_INDEX : PH_DONE;
      CODE_PLAYER_TIME: begin
        players_left = (players_left - 1) & 8'hFF;
        if (players_left == 0) return PH_DONE;
        player_no = player_no + 7'd1;
        return CODE_PLAYER_INDEX;
      end
      default: return p + 5'd1;
    endcase
  endfunction

  // returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, input logic l, output result_t r);
    bit          have;
    logic [4:0]  code;
    logic [63:0] val;
    logic [6:0]  slot;
    logic        send;
    have = 1'b0;
    code = CODE_NONE;
    val = '0;
    slot = '0;
    send = 1'b0;
    if (byte_pos < BYTE_LIMIT) begin
      if (phase == PH_HEADER) begin
        if (byte_pos == 4) begin
          if (b == TYPE_INFO) phase = CODE_PROTOCOL;
          else if (b == TYPE_CHALLENGE) phase = CODE_CHALLENGE;
          else if (b == TYPE_PLAYERS) phase = CODE_PLAYER_COUNT;
          else phase = PH_DONE;
        end
      end else if (phase != PH_DONE) begin
        if (phase >= CODE_PLAYER_INDEX && phase <= CODE_PLAYER_TIME) slot = player_no;
        if (text_phase(phase)) begin
          have = 1'b1;
          code = phase;
          val = 64'(b);
          send = (b == 8'd0);
          if (b == 8'd0) phase = advance(phase);
        end else begin
          acc = acc | (64'(b) << (8 * acc_idx));
          if (acc_idx + 1 < width_of(phase)) begin
            acc_idx++;
          end else begin
            val = acc;
            acc = '0;
            acc_idx = 0;
            code = phase;
            have = 1'b1;
            case (phase)
              CODE_APP_ID: app_id = val[15:0];
              CODE_EDF: edf_flags = val[7:0];
              CODE_PLAYER_COUNT: begin
                if (val > 64'(SLOT_LIMIT)) val = 64'(SLOT_LIMIT);
                players_left = int'(val[7:0]);
                player_no = '0;
              end
              CODE_CHALLENGE: have = l;
              CODE_PLAYER_SCORE: val = {{32{val[31]}}, val[31:0]};
              default: ;
            endcase
            phase = advance(phase);
          end
        end
      end
      byte_pos++;
    end
    if (!have) begin
      code = CODE_NONE;
      val = '0;
      slot = '0;
      send = 1'b0;
    end
    if (l) begin
      clear_parse();
      have = 1'b1;
    end
    r = '{code: code, value: val, slot: slot, str_end: send, pkt_end: l};
    return have;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    if (errors <= 40)
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      fields_seen++;
      if (field_q.size() == 0) begin
        report("unexpected result, code", 64'(out_field_code), 64'(CODE_NONE));
      end else begin
        e = field_q.pop_front();
        if (out_field_code !== e.code)
          report("field_code", 64'(out_field_code), 64'(e.code));
        if (out_field_value !== e.value) report("field_value", out_field_value, e.value);
        if (out_player_slot !== e.slot)
          report("player_slot", 64'(out_player_slot), 64'(e.slot));
        if (out_string_end !== e.str_end)
          report("string_end", 64'(out_string_end), 64'(e.str_end));
        if (out_packet_end !== e.pkt_end)
          report("packet_end", 64'(out_packet_end), 64'(e.pkt_end));
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall) stall_left <= quiet ? 0 : $urandom_range(0, 5);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    result_t r;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (parse_byte(b, l, r)) field_q.push_back(r);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_item(pkt[i], i == pkt.size() - 1);
    pkt.delete();
    datagrams++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (field_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_ship_id(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    ship_app_id = v;
    cfg_we <= 1'b0;
  endtask

  task automatic put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) pkt.push_back(v[8*i +: 8]);
  endtask

  task automatic put_str(input int len);
    repeat (len) pkt.push_back(8'($urandom_range(1, 255)));
    pkt.push_back(8'd0);
  endtask

  task automatic put_head(input logic [7:0] kind);
    put_le({$urandom, $urandom}, 4);
    pkt.push_back(kind);
  endtask

  task automatic build_info(input bit ship, input logic [7:0] flags);
    put_head(TYPE_INFO);
    pkt.push_back(8'($urandom));
    repeat (4) put_str($urandom_range(0, 5));
    put_le(ship ? ship_app_id : 16'($urandom), 2);
    put_le($urandom, 7);
    if (ship) put_le($urandom, 3);
    put_str($urandom_range(0, 4));
    pkt.push_back(flags);
    if (flags & EDF_PORT) put_le($urandom, 2);
    if (flags & EDF_STEAM_ID) put_le({$urandom, $urandom}, 8);
    if (flags & EDF_RELAY) begin
      put_le($urandom, 2);
      put_str($urandom_range(0, 4));
    end
    if (flags & EDF_KEYWORDS) put_str($urandom_range(0, 6));
    if (flags & EDF_GAME_ID) put_le({$urandom, $urandom}, 8);
  endtask

  task automatic build_players(input logic [7:0] count, input int name_max);
    int n;
    put_head(TYPE_PLAYERS);
    pkt.push_back(count);
    n = (count > SLOT_LIMIT) ? SLOT_LIMIT : count;
    repeat (n) begin
      pkt.push_back(8'($urandom));
      put_str($urandom_range(0, name_max));
      put_le($urandom, 4);
      put_le($urandom, 4);
    end
  endtask

  task automatic test_directed();
    // info reply with ship bytes and every optional field
    put_head(TYPE_INFO);
    pkt.push_back(8'h11);
    pkt.push_back(8'hFF); pkt.push_back(8'h01); pkt.push_back(8'h00);
    put_str(0); put_str(1); put_str(0);
    put_le(ship_app_id, 2);
    put_le(56'hFF_00_80_7F_01_FE_00, 7);
    put_le(24'hFF_00_AA, 3);
    put_str(2);
    pkt.push_back(8'hF1);
    put_le(16'hFFFF, 2);
    put_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
    put_le(16'h0000, 2);
    put_str(1); put_str(0);
    put_le(64'h8000_0000_0000_0001, 8);
    pkt.push_back(8'h5A);
    send_packet();
    // challenge exact, too long, too short
    put_head(TYPE_CHALLENGE); put_le(32'h8001_FF7F, 4); send_packet();
    put_head(TYPE_CHALLENGE); put_le(40'h12_3456_789A, 5); send_packet();
    put_head(TYPE_CHALLENGE); put_le(24'hFFFFFF, 3); send_packet();
    // players with negative and positive score, and an over-range count
    put_head(TYPE_PLAYERS); pkt.push_back(8'd2);
    pkt.push_back(8'h00); put_str(1); put_le(32'hFFFF_FFFE, 4); put_le(32'h3F80_0000, 4);
    pkt.push_back(8'hFF); put_str(0); put_le(32'h7FFF_FFFF, 4); put_le(32'hFFFF_FFFF, 4);
    send_packet();
    put_head(TYPE_PLAYERS); pkt.push_back(8'hFF); pkt.push_back(8'h01); send_packet();
    put_head(TYPE_PLAYERS); pkt.push_back(8'h00); pkt.push_back(8'h33); send_packet();
    // unknown type, short datagrams, header only, field cut by the end
    put_head(TYPE_UNKNOWN); put_le(32'hDEAD_BEEF, 4); send_packet();
    pkt.push_back(8'h00); send_packet();
    put_head(TYPE_INFO); send_packet();
    put_head(TYPE_INFO); pkt.push_back(8'h11); pkt.push_back(8'h41); send_packet();
    build_info(1'b0, 8'h80); repeat (2) void'(pkt.pop_back()); send_packet();
    drain();
  endtask

  task automatic test_config_sweep();
    logic [15:0] ids[4];
    ids = '{16'h0000, 16'hFFFF, 16'd2400, 16'($urandom)};
    foreach (ids[i]) begin
      write_ship_id(ids[i]);
      build_info(1'b1, 8'($urandom)); send_packet();
      build_info(1'b0, 8'h00); send_packet();
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    build_players(8'd12, 6);
    send_packet();
    drain();
  endtask

  task automatic test_overlong();
    // a full player list padded with trailing bytes runs past the byte limit
    build_players(8'd128, 5);
    while (pkt.size() < BYTE_LIMIT + 40) pkt.push_back(8'($urandom));
    send_packet();
    drain();
  endtask

  task automatic test_random();
    int target;
    int pick;
    int cut;
    target = items_sent + 300;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 4) begin
        drain();
        quiet = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 1) == 0) write_ship_id(16'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) build_info($urandom_range(0, 1), 8'($urandom));
      else if (pick < 60) put_head(TYPE_CHALLENGE);
      else if (pick < 85) build_players(8'($urandom_range(0, 4)), 4);
      else if (pick < 88) build_players(8'($urandom), 0);
      else begin
        repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
      end
      if (pick >= 45 && pick < 60) put_le($urandom, ($urandom_range(0, 4) == 0) ?
                                           $urandom_range(0, 7) : 4);
      if (pick < 88 && $urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
      send_packet();
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    ship_app_id = 16'd2400;
    clear_parse();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_overlong();
    test_random();
    write_ship_id(16'd2400);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d datagrams, %0d bytes and %0d results", datagrams, items_sent,
             fields_seen);
    $display("info, challenge, player and noise replies with cuts, overruns and stalls");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", field_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
